// ----- src/waypoint_heading_distance_controller_macros.svh -----
// Assertion macros used by the checker file.
`ifndef WAYPOINT_HEADING_DISTANCE_CONTROLLER_MACROS_SVH
`define WAYPOINT_HEADING_DISTANCE_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define WHDC_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("whdc assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define WHDC_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("whdc assertion failed");

`endif

// ----- src/whdc_pkg.sv -----
package whdc_pkg;

	typedef enum logic [2:0] {
		REG_DEST_X        = 3'd0,
		REG_DEST_Y        = 3'd1,
		REG_DEST_HEADING  = 3'd2,
		REG_HEADING_GAIN  = 3'd3,
		REG_DISTANCE_GAIN = 3'd4,
		REG_DAMPING_GAIN  = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic start;
		logic hyper;
	} cordic_ctl_t;

	localparam logic signed [26:0] PI_Q20     = 27'sd3294199;
	localparam logic signed [26:0] TWO_PI_Q20 = 27'sd6588398;
	localparam logic [22:0]        FINE_LIM   = 23'd36602;
	localparam logic [22:0]        COARSE_LIM = 23'd54903;
	localparam logic [21:0]        NEAR_LIM   = 22'd204;
	localparam logic [21:0]        SLOW_LIM   = 22'd409;
	localparam logic signed [53:0] LIN_CAP    = 54'sd328;
	localparam logic [26:0]        GAIN_1P3   = 27'd85197;
	localparam logic [31:0]        ONE_Q20    = 32'd1048576;

	function automatic logic [19:0] circ_atan(input logic [4:0] idx);
		case (idx)
			5'd0:  circ_atan = 20'd823550;
			5'd1:  circ_atan = 20'd486170;
			5'd2:  circ_atan = 20'd256879;
			5'd3:  circ_atan = 20'd130396;
			5'd4:  circ_atan = 20'd65451;
			5'd5:  circ_atan = 20'd32757;
			5'd6:  circ_atan = 20'd16383;
			5'd7:  circ_atan = 20'd8192;
			5'd8:  circ_atan = 20'd4096;
			5'd9:  circ_atan = 20'd2048;
			5'd10: circ_atan = 20'd1024;
			5'd11: circ_atan = 20'd512;
			5'd12: circ_atan = 20'd256;
			5'd13: circ_atan = 20'd128;
			5'd14: circ_atan = 20'd64;
			5'd15: circ_atan = 20'd32;
			5'd16: circ_atan = 20'd16;
			5'd17: circ_atan = 20'd8;
			5'd18: circ_atan = 20'd4;
			5'd19: circ_atan = 20'd2;
			5'd20: circ_atan = 20'd1;
			5'd21: circ_atan = 20'd1;
			default: circ_atan = 20'd0;
		endcase
	endfunction

	function automatic logic [19:0] hyp_atanh(input logic [4:0] idx);
		case (idx)
			5'd1:  hyp_atanh = 20'd575989;
			5'd2:  hyp_atanh = 20'd267820;
			5'd3:  hyp_atanh = 20'd131761;
			5'd4:  hyp_atanh = 20'd65622;
			5'd5:  hyp_atanh = 20'd32779;
			5'd6:  hyp_atanh = 20'd16385;
			5'd7:  hyp_atanh = 20'd8192;
			5'd8:  hyp_atanh = 20'd4096;
			5'd9:  hyp_atanh = 20'd2048;
			5'd10: hyp_atanh = 20'd1024;
			5'd11: hyp_atanh = 20'd512;
			5'd12: hyp_atanh = 20'd256;
			5'd13: hyp_atanh = 20'd128;
			5'd14: hyp_atanh = 20'd64;
			5'd15: hyp_atanh = 20'd32;
			5'd16: hyp_atanh = 20'd16;
			5'd17: hyp_atanh = 20'd8;
			5'd18: hyp_atanh = 20'd4;
			5'd19: hyp_atanh = 20'd2;
			5'd20: hyp_atanh = 20'd1;
			5'd21: hyp_atanh = 20'd1;
			default: hyp_atanh = 20'd0;
		endcase
	endfunction

	// Wrap an angle into [-pi, pi] with up to two full-turn corrections.
	function automatic logic signed [26:0] wrap_pi(input logic signed [26:0] e);
		logic signed [26:0] v;
		v = e;
		for (int k = 0; k < 2; k++) begin
			if (v > PI_Q20) v = v - TWO_PI_Q20;
			if (v < -PI_Q20) v = v + TWO_PI_Q20;
		end
		return v;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [53:0] v);
		if (v > 54'sd32767) return 16'sh7fff;
		if (v < -54'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

endpackage

// ----- src/whdc_if.sv -----
interface whdc_pose_if;
	logic               valid;
	logic               ready;
	logic signed [19:0] pos_x;
	logic signed [19:0] pos_y;
	logic signed [14:0] heading;
	logic signed [15:0] speed;

	modport source (output valid, pos_x, pos_y, heading, speed, input ready);
	modport sink (input valid, pos_x, pos_y, heading, speed, output ready);
endinterface

interface whdc_cmd_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] linear_cmd;
	logic signed [15:0] angular_cmd;
	logic               phase_out;
	logic               done_res;

	modport source (output valid, linear_cmd, angular_cmd, phase_out, done_res,
		input ready);
	modport sink (input valid, linear_cmd, angular_cmd, phase_out, done_res,
		output ready);
endinterface

// ----- src/whdc_isqrt.sv -----
module whdc_isqrt #(
	parameter int W = 44
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [W-1:0]     rad,
	output logic [W/2-1:0]   root,
	output logic             done
);
	logic [W-1:0] v_q;
	logic [W-1:0] r_q;
	logic [W-1:0] bit_q;
	logic         busy_q;
	logic         done_q;
	logic [W:0]   trial;

	assign trial = {1'b0, r_q} + {1'b0, bit_q};
	assign root  = r_q[W/2-1:0];
	assign done  = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !start && bit_q[0];
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= rad;
			r_q   <= '0;
			bit_q <= {2'b01, {(W-2){1'b0}}};
		end else if (busy_q) begin
			if ({1'b0, v_q} >= trial) begin
				v_q <= W'({1'b0, v_q} - trial);
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule

// ----- src/whdc_cordic.sv -----
module whdc_cordic #(
	parameter int ITER = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  whdc_pkg::cordic_ctl_t ctl,
	input  logic signed [31:0]  x0,
	input  logic signed [31:0]  y0,
	input  logic signed [25:0]  z0,
	output logic signed [31:0]  x,
	output logic signed [31:0]  y,
	output logic signed [25:0]  z,
	output logic                done
);
	import whdc_pkg::*;

	localparam int NW = $clog2(ITER + 1);

	logic signed [31:0] x_q, y_q, xs, ys;
	logic signed [25:0] z_q, tab;
	logic [NW-1:0]      n_q;
	logic [4:0]         s_q, sh;
	logic               again_q, hyp_q, busy_q, done_q;
	logic               pos;

	always_comb begin
		sh  = hyp_q ? s_q : 5'(n_q);
		xs  = x_q >>> sh;
		ys  = y_q >>> sh;
		tab = hyp_q ? 26'(hyp_atanh(s_q)) : 26'(circ_atan(sh));
		pos = hyp_q ? (z_q >= 26'sd0) : (y_q > 32'sd0);
	end

	assign x    = x_q;
	assign y    = y_q;
	assign z    = z_q;
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			n_q     <= '0;
			s_q     <= 5'd1;
			again_q <= 1'b0;
			hyp_q   <= 1'b0;
		end else begin
			done_q <= busy_q && !ctl.start && (n_q == NW'(ITER - 1));
			if (ctl.start) begin
				busy_q  <= 1'b1;
				n_q     <= '0;
				s_q     <= 5'd1;
				again_q <= 1'b0;
				hyp_q   <= ctl.hyper;
			end else if (busy_q) begin
				n_q <= n_q + 1'b1;
				if (n_q == NW'(ITER - 1)) begin
					busy_q <= 1'b0;
				end
				// Hyperbolic passes repeat shifts four and thirteen for convergence.
				if ((s_q == 5'd4 || s_q == 5'd13) && !again_q) begin
					again_q <= 1'b1;
				end else begin
					again_q <= 1'b0;
					s_q     <= s_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
		end else if (busy_q) begin
			if (hyp_q) begin
				x_q <= pos ? x_q + ys : x_q - ys;
				y_q <= pos ? y_q + xs : y_q - xs;
				z_q <= pos ? z_q - tab : z_q + tab;
			end else begin
				x_q <= pos ? x_q + ys : x_q - ys;
				y_q <= pos ? y_q - xs : y_q + xs;
				z_q <= pos ? z_q + tab : z_q - tab;
			end
		end
	end
endmodule

// ----- src/whdc_div.sv -----
module whdc_div #(
	parameter int NW = 46,
	parameter int DW = 27,
	parameter int QW = 22
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo,
	output logic          done
);
	localparam int CW = $clog2(QW);

	logic [DW:0]   rem_q, trial;
	logic [QW-1:0] low_q, q_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q, take;

	assign trial = {rem_q[DW-1:0], low_q[QW-1]};
	assign take  = trial >= {1'b0, den_q};
	assign quo   = q_q;
	assign done  = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CW'(QW - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// The upper dividend bits are known to be below the divisor, so only
	// the low quotient bits are developed.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= (DW+1)'(num[NW-1:QW]);
			low_q <= num[QW-1:0];
			den_q <= den;
			q_q   <= '0;
		end else if (busy_q) begin
			rem_q <= take ? trial - {1'b0, den_q} : trial;
			low_q <= low_q << 1;
			q_q   <= {q_q[QW-2:0], take};
		end
	end
endmodule

// ----- src/waypoint_heading_distance_controller.sv -----
// A command word follows each accepted pose word, after any wait on the command side. In approach,
// a word whose linear command is held or zeroed skips the distance and damping gain states.
// One pose word is in work at a time; the next is taken when the sequencer is back in idle.
// The time is set by the 22-step square root, the one-step-per-cycle CORDIC and the
// 22-step divider, all driven in turn by one sequencer and one shared multiplier.
// Reset (arst_n low, asynchronous) restores register defaults, approach phase and counters.
module waypoint_heading_distance_controller #(
	parameter int SETTLE_STEPS      = 30,
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	whdc_pose_if.sink          pose,
	whdc_cmd_if.source         cmd,
	input  logic               cfg_we,
	input  whdc_pkg::cfg_idx_t cfg_index,
	input  logic [19:0]        cfg_data
);
	import whdc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_SQX, S_SQY, S_SQRT, S_ATAN, S_ERR, S_HG, S_DG, S_DM,
		S_HYP, S_DIV1, S_TSQ, S_DIV, S_GAIN, S_OUT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic signed [19:0] dest_x_q, dest_y_q;
	logic signed [14:0] dest_hd_q;
	logic [15:0]        hgain_q, dgain_q, mgain_q;

	// Working registers of the current word.
	logic signed [20:0] dx_q, dy_q;
	logic signed [14:0] hd_q;
	logic signed [15:0] spd_q;
	logic [43:0]        sqx_q, rad_q;
	logic [21:0]        d_q;
	logic signed [22:0] e_q, t_q;
	logic signed [39:0] p1_q;
	logic signed [15:0] lin_q, ang_q, last_q;
	logic               align_q, done_q, k_q;

	// Controller state.
	logic               phase_q;
	logic [5:0]         yaw_q;

	// Output register.
	logic               ovalid_q, oph_q, odone_q;
	logic signed [15:0] olin_q, oang_q;

	// Shared unit hookup.
	logic               sq_start_q, sq_done;
	logic [21:0]        sq_root;
	cordic_ctl_t        cd_ctl_q;
	logic signed [31:0] cd_x0_q, cd_y0_q, cd_x, cd_y;
	logic signed [25:0] cd_z0_q, cd_z;
	logic               cd_done;
	logic               dv_start_q, dv_done, dv_neg_q;
	logic [45:0]        dv_num_q;
	logic [26:0]        dv_den_q;
	logic [21:0]        dv_quo;

	// The one multiplier; its operands follow the state.
	logic signed [26:0] mul_a, mul_b;
	logic signed [53:0] prod;

	// Derived values used by single states.
	logic signed [31:0] ax, ay;
	logic signed [26:0] err_raw, err_w, al_raw, al_w, al_neg;
	logic [22:0]        ae;
	logic signed [53:0] rnd24, lin_sum, lin_rnd;
	logic [22:0]        t_mag;
	logic [43:0]        tsq;
	logic signed [22:0] q_signed;

	always_comb begin
		case (state_q)
			S_SQX: begin
				mul_a = 27'(dx_q);
				mul_b = 27'(dx_q);
			end
			S_SQY: begin
				mul_a = 27'(dy_q);
				mul_b = 27'(dy_q);
			end
			S_HG: begin
				mul_a = 27'({11'b0, hgain_q});
				mul_b = 27'(e_q);
			end
			S_DG: begin
				mul_a = 27'({11'b0, dgain_q});
				mul_b = 27'({5'b0, d_q});
			end
			S_DM: begin
				mul_a = 27'({11'b0, mgain_q});
				mul_b = 27'(spd_q);
			end
			S_TSQ: begin
				mul_a = 27'(t_q);
				mul_b = 27'(t_q);
			end
			S_GAIN: begin
				mul_a = GAIN_1P3;
				mul_b = 27'(t_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod = mul_a * mul_b;
	end

	always_comb begin
		ax       = {{3{dx_q[20]}}, dx_q, 8'b0};
		ay       = {{3{dy_q[20]}}, dy_q, 8'b0};
		// Bearing minus heading minus pi, since the bearing is taken toward the pose.
		err_raw  = 27'(cd_z) - 27'($signed({hd_q, 8'b0})) - PI_Q20;
		err_w    = wrap_pi(err_raw);
		al_raw   = 27'($signed({(16'(hd_q) - 16'(dest_hd_q)), 8'b0}));
		al_w     = wrap_pi(al_raw);
		al_neg   = -al_w;
		ae       = e_q[22] ? 23'(-e_q) : 23'(e_q);
		rnd24    = (prod + (54'sd1 <<< 23)) >>> 24;
		lin_sum  = 54'(p1_q) + prod;
		lin_rnd  = (lin_sum + (54'sd1 <<< 15)) >>> 16;
		t_mag    = t_q[22] ? 23'(-t_q) : 23'(t_q);
		tsq      = prod[43:0];
		q_signed = dv_neg_q ? -23'({1'b0, dv_quo}) : 23'({1'b0, dv_quo});
	end

	assign pose.ready      = (state_q == S_IDLE);
	assign cmd.valid       = ovalid_q;
	assign cmd.linear_cmd  = olin_q;
	assign cmd.angular_cmd = oang_q;
	assign cmd.phase_out   = oph_q;
	assign cmd.done_res    = odone_q;

	whdc_isqrt #(.W(44)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start_q),
		.rad    (rad_q),
		.root   (sq_root),
		.done   (sq_done)
	);

	whdc_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cd_ctl_q),
		.x0     (cd_x0_q),
		.y0     (cd_y0_q),
		.z0     (cd_z0_q),
		.x      (cd_x),
		.y      (cd_y),
		.z      (cd_z),
		.done   (cd_done)
	);

	whdc_div #(.NW(46), .DW(27), .QW(22)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start_q),
		.num    (dv_num_q),
		.den    (dv_den_q),
		.quo    (dv_quo),
		.done   (dv_done)
	);

	// Configuration writes are expected only while no word is in work.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_x_q  <= '0;
			dest_y_q  <= '0;
			dest_hd_q <= '0;
			hgain_q   <= 16'd32768;
			dgain_q   <= 16'd1966;
			mgain_q   <= 16'd9830;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEST_X:        dest_x_q  <= cfg_data;
				REG_DEST_Y:        dest_y_q  <= cfg_data;
				REG_DEST_HEADING:  dest_hd_q <= cfg_data[14:0];
				REG_HEADING_GAIN:  hgain_q   <= cfg_data[15:0];
				REG_DISTANCE_GAIN: dgain_q   <= cfg_data[15:0];
				REG_DAMPING_GAIN:  mgain_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			phase_q    <= 1'b0;
			yaw_q      <= '0;
			last_q     <= '0;
			ovalid_q   <= 1'b0;
			sq_start_q <= 1'b0;
			cd_ctl_q   <= '0;
			dv_start_q <= 1'b0;
			k_q        <= 1'b0;
		end else begin
			// Start pulses for the shared units, one cycle each.
			sq_start_q     <= (state_q == S_SQY);
			cd_ctl_q.start <= (state_q == S_SQRT) && sq_done;
			dv_start_q     <= (state_q == S_HYP && cd_done && cd_x > 32'sd0) ||
				(state_q == S_TSQ);
			if (ovalid_q && cmd.ready && state_q != S_OUT) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (pose.valid) begin
						dx_q    <= 21'(pose.pos_x) - 21'(dest_x_q);
						dy_q    <= 21'(pose.pos_y) - 21'(dest_y_q);
						hd_q    <= pose.heading;
						spd_q   <= pose.speed;
						state_q <= S_SQX;
					end
				end
				S_SQX: begin
					sqx_q   <= prod[43:0];
					state_q <= S_SQY;
				end
				S_SQY: begin
					rad_q   <= sqx_q + prod[43:0];
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (sq_done) begin
						d_q <= sq_root;
						if (!phase_q && sq_root > NEAR_LIM) begin
							// Circular vectoring, pre-rotated by pi for the left half plane.
							cd_ctl_q.hyper <= 1'b0;
							if (dx_q[20]) begin
								cd_x0_q <= -ax;
								cd_y0_q <= -ay;
								cd_z0_q <= dy_q[20] ? -26'(PI_Q20) : 26'(PI_Q20);
							end else begin
								cd_x0_q <= ax;
								cd_y0_q <= ay;
								cd_z0_q <= '0;
							end
							align_q <= 1'b0;
							state_q <= S_ATAN;
						end else begin
							// Near the goal or already aligning: hyperbolic rotation for tanh.
							phase_q        <= 1'b1;
							align_q        <= 1'b1;
							cd_ctl_q.hyper <= 1'b1;
							cd_x0_q        <= $signed(ONE_Q20);
							cd_y0_q        <= '0;
							cd_z0_q        <= 26'(al_neg >>> 2);
							state_q        <= S_HYP;
						end
					end
				end
				S_ATAN: begin
					if (cd_done) begin
						e_q     <= 23'(err_w);
						state_q <= S_ERR;
					end
				end
				S_ERR: begin
					state_q <= S_HG;
				end
				S_HG: begin
					done_q <= 1'b0;
					if (ae < FINE_LIM) begin
						ang_q   <= sat16(rnd24);
						state_q <= S_DG;
					end else if (ae < COARSE_LIM && d_q <= SLOW_LIM) begin
						// Slow zone with a moderate error: stop and turn in place later.
						lin_q   <= '0;
						ang_q   <= '0;
						last_q  <= '0;
						state_q <= S_OUT;
					end else begin
						ang_q   <= sat16(rnd24);
						lin_q   <= last_q;
						state_q <= S_OUT;
					end
				end
				S_DG: begin
					p1_q    <= prod[39:0];
					state_q <= S_DM;
				end
				S_DM: begin
					if (lin_rnd > LIN_CAP) begin
						lin_q  <= 16'(LIN_CAP);
						last_q <= 16'(LIN_CAP);
					end else begin
						lin_q  <= sat16(lin_rnd);
						last_q <= sat16(lin_rnd);
					end
					state_q <= S_OUT;
				end
				S_HYP: begin
					if (cd_done) begin
						if (cd_x > 32'sd0) begin
							dv_neg_q   <= cd_y[31];
							dv_num_q   <= {(cd_y[31] ? 26'(-cd_y) : 26'(cd_y)), 20'b0};
							dv_den_q   <= cd_x[26:0];
							state_q    <= S_DIV1;
						end else begin
							t_q     <= '0;
							k_q     <= 1'b0;
							state_q <= S_TSQ;
						end
					end
				end
				S_DIV1: begin
					if (dv_done) begin
						t_q     <= q_signed;
						k_q     <= 1'b0;
						state_q <= S_TSQ;
					end
				end
				S_TSQ: begin
					// Doubling rule t = 2t / (1 + t*t).
					dv_neg_q   <= t_q[22];
					dv_num_q   <= 46'({t_mag, 21'b0});
					dv_den_q   <= 27'(ONE_Q20) + 27'(tsq[43:20]);
					state_q    <= S_DIV;
				end
				S_DIV: begin
					if (dv_done) begin
						t_q <= q_signed;
						if (k_q) begin
							state_q <= S_GAIN;
						end else begin
							k_q     <= 1'b1;
							state_q <= S_TSQ;
						end
					end
				end
				S_GAIN: begin
					ang_q  <= sat16(rnd24);
					lin_q  <= '0;
					last_q <= '0;
					if (yaw_q >= 6'(SETTLE_STEPS)) begin
						done_q  <= 1'b1;
						phase_q <= 1'b0;
						yaw_q   <= '0;
					end else begin
						done_q <= 1'b0;
						yaw_q  <= yaw_q + 1'b1;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					// Wait for the previous command word to drain before loading.
					if (!ovalid_q || cmd.ready) begin
						ovalid_q <= 1'b1;
						olin_q   <= lin_q;
						oang_q   <= ang_q;
						oph_q    <= align_q;
						odone_q  <= done_q;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- src/whdc_checker.sv -----
module whdc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pose_valid,
	input logic        pose_ready,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic [15:0] linear_cmd,
	input logic        phase_out,
	input logic        done_res
);
`include "waypoint_heading_distance_controller_macros.svh"

	`WHDC_ASSERT_NEXT(a_busy_after_accept, pose_valid && pose_ready, !pose_ready)
	`WHDC_ASSERT_NOW(a_done_in_align, cmd_valid && done_res, phase_out)
	`WHDC_ASSERT_NOW(a_align_no_linear, cmd_valid && phase_out, linear_cmd == 16'd0)
	`WHDC_ASSERT_NEXT(a_valid_holds, cmd_valid && !cmd_ready, cmd_valid)
	`WHDC_ASSERT_NEXT(a_payload_holds, cmd_valid && !cmd_ready, $stable(linear_cmd))
endmodule

bind waypoint_heading_distance_controller whdc_checker u_whdc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pose_valid (pose.valid),
	.pose_ready (pose.ready),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.linear_cmd (cmd.linear_cmd),
	.phase_out  (cmd.phase_out),
	.done_res   (cmd.done_res)
);
